// ===== hw/rtl/index_allocator_free_stack_core_defines.svh =====
// Assertion macros shared by the index allocator RTL.
// Needs clock and reset (synchronous, active high) in the using module.
`ifndef INDEX_ALLOCATOR_FREE_STACK_CORE_DEFINES_SVH
`define INDEX_ALLOCATOR_FREE_STACK_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IAFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define IAFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/iafs_pkg.sv =====
// Shared types and constants for the index allocator free stack.
// No dependencies; imported by every module of the block except iafs_ram.
`timescale 1ns / 1ps
`default_nettype none

package iafs_pkg;

   localparam int SLOT_DEPTH = 1024;
   localparam int IDX_W      = $clog2(SLOT_DEPTH);
   localparam int CNT_W      = IDX_W + 1;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_DUP   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic exec;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/iafs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iafs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/iafs_dpath.sv =====
// Datapath: stack and free-flag memories, counters, limit register, result register.
// Depends on iafs_pkg, iafs_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "index_allocator_free_stack_core_defines.svh"

module iafs_dpath
   import iafs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_cmd_type       cmd,
   output dp_status_type           status,
   input  wire logic               req_command,
   input  wire logic [IDX_W-1:0]   req_slot_index,
   input  wire logic               csr_wr_en,
   input  wire logic [CNT_W-1:0]   csr_wr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [IDX_W-1:0]   rsp_granted_index,
   output logic      [1:0]         rsp_status
);

   logic             cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] next_fresh_ff, next_fresh_in;
   logic [CNT_W-1:0] slot_limit_ff;
   logic [IDX_W-1:0] clr_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_granted_ff, rsp_granted_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0] lim;
   logic [CNT_W-1:0] top_pos;
   logic [IDX_W-1:0] stack_rd_data;
   logic             stack_we;
   logic             flag_rd_data;
   logic             flag_we;
   logic [IDX_W-1:0] flag_wr_addr;
   logic             flag_wr_data;

   // limits above the built depth act as the depth
   assign lim     = (slot_limit_ff > CNT_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH) : slot_limit_ff;
   assign top_pos = free_count_ff - CNT_W'(1);

   iafs_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (free_count_ff[IDX_W-1:0]),
      .wr_data (idx_ff),
      .rd_en   (cmd.accept),
      .rd_addr (top_pos[IDX_W-1:0]),
      .rd_data (stack_rd_data)
   );

   iafs_ram #(.WIDTH(1), .DEPTH(SLOT_DEPTH)) u_flags (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_wr_addr),
      .wr_data (flag_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_slot_index),
      .rd_data (flag_rd_data)
   );

   always_comb begin
      free_count_in  = free_count_ff;
      next_fresh_in  = next_fresh_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      stack_we       = 1'b0;
      flag_we        = 1'b0;
      flag_wr_addr   = clr_ff;
      flag_wr_data   = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (cmd.clear_step) begin
         flag_we = 1'b1;
      end

      if (cmd.exec) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = '0;
         rsp_status_in  = STATUS_OK;
         if (cmd_ff == CMD_ALLOC) begin
            if (free_count_ff != '0) begin
               // pop: top entry was read in the accept cycle
               free_count_in  = top_pos;
               rsp_granted_in = stack_rd_data;
               flag_we        = 1'b1;
               flag_wr_addr   = stack_rd_data;
               flag_wr_data   = 1'b0;
            end else if (next_fresh_ff >= lim) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               rsp_granted_in = next_fresh_ff[IDX_W-1:0];
               next_fresh_in  = next_fresh_ff + CNT_W'(1);
            end
         end else begin
            if ({1'b0, idx_ff} >= lim) begin
               rsp_status_in = STATUS_RANGE;
            end else if (flag_rd_data) begin
               rsp_status_in = STATUS_DUP;
            end else if (free_count_ff < CNT_W'(SLOT_DEPTH)) begin
               stack_we      = 1'b1;
               free_count_in = free_count_ff + CNT_W'(1);
               flag_we       = 1'b1;
               flag_wr_addr  = idx_ff;
               flag_wr_data  = 1'b1;
            end else begin
               rsp_status_in = STATUS_DUP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         next_fresh_ff <= '0;
         slot_limit_ff <= CNT_W'(SLOT_DEPTH);
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            slot_limit_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_command;
         idx_ff <= req_slot_index;
      end
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign status.clear_last = (clr_ff == IDX_W'(SLOT_DEPTH - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;

   `IAFS_ASSERT_NOW(a_count_bound, 1'b1, free_count_ff <= CNT_W'(SLOT_DEPTH), "free count above depth")
   `IAFS_ASSERT_NOW(a_fresh_bound, 1'b1, next_fresh_ff <= CNT_W'(SLOT_DEPTH), "fresh counter above depth")
   `IAFS_ASSERT_NEXT(a_pop_dec, cmd.exec && cmd_ff == CMD_ALLOC && free_count_ff != '0, free_count_ff + CNT_W'(1) == $past(free_count_ff), "pop did not shrink stack")
   `IAFS_ASSERT_NEXT(a_exec_rsp, cmd.exec, rsp_valid_ff, "no result after execute")

endmodule

`default_nettype wire

// ===== hw/rtl/iafs_ctrl.sv =====
// Controller: sequences memory clear after reset, request accept and execute.
// Depends on iafs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "index_allocator_free_stack_core_defines.svh"

module iafs_ctrl
   import iafs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.accept     = 1'b0;
      cmd.exec       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // result slot frees up this cycle or is already empty
            req_ready  = !status.rsp_busy;
            cmd.accept = req_valid && !status.rsp_busy;
            if (cmd.accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   `IAFS_ASSERT_NEXT(a_accept_exec, cmd.accept, state_ff == ST_EXEC, "accept not followed by execute")

endmodule

`default_nettype wire

// ===== hw/rtl/index_allocator_free_stack_core.sv =====
// Top level of the slot index allocator with a LIFO free stack.
// Depends on iafs_pkg, iafs_ctrl, iafs_dpath (which holds two iafs_ram instances).
`timescale 1ns / 1ps
`default_nettype none

// Slot index allocator. Each request word either allocates an index (command 0)
// or frees the given index (command 1) and yields exactly one response word.
// Allocate pops the most recently freed index; with an empty free stack it
// hands out the next never-used index, or reports full once that counter
// reaches the limit. Free reports out of range for an index at or above the
// limit, already free for an index on the stack, else pushes it. Freeing an
// index that was never handed out is accepted.
// Timing: after reset the free-flag memory is cleared one entry a cycle, and
// req_ready stays low until every one of the SLOT_DEPTH (1024) entries is
// clear; csr writes are taken during that time. After that the accept cycle
// issues the registered reads of the stack top and of the index's free flag,
// and the next cycle decides and writes the result register. A new word is
// accepted only once the previous one has been executed, and a response still
// waiting in the output register holds off the next accept.
// csr_wr_data sets slot_limit (reset 1024); values above the depth act as the
// depth. Write it only while no request is in flight.

module index_allocator_free_stack_core
   import iafs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_command,
   input  wire logic [IDX_W-1:0] req_slot_index,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [IDX_W-1:0] rsp_granted_index,
   output logic      [1:0]       rsp_status,
   // limit register
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // state machine: clear pass, idle/accept, execute
   iafs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, counters and response register
   iafs_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_command),
      .req_slot_index    (req_slot_index),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

// ===== bench/index_allocator_free_stack_checker.sv =====
`timescale 1ns / 1ps
// Checker for the slot index allocator: watches request, response and limit ports.
// Predicts each response from its own copy of the free stack. Depends on iafs_pkg.

module index_allocator_free_stack_checker
   import iafs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_command,
   input  logic [IDX_W-1:0] req_slot_index,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [IDX_W-1:0] rsp_granted_index,
   input  logic [1:0]       rsp_status,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      logic [IDX_W-1:0] granted;
      status_type       status;
   } grant_word_type;

   // shadow allocator state
   logic [IDX_W-1:0] stack_mem [SLOT_DEPTH];
   bit               is_free   [SLOT_DEPTH];
   logic [CNT_W-1:0] stack_depth;
   logic [CNT_W-1:0] fresh_next;
   logic [CNT_W-1:0] limit_reg;

   grant_word_type pending_grants [$];
   grant_word_type want;
   int             errors = 0;

   function automatic grant_word_type predict_grant(input logic cmd,
                                                    input logic [IDX_W-1:0] idx);
      grant_word_type   r;
      logic [CNT_W-1:0] lim;
      r.granted = '0;
      r.status  = STATUS_OK;
      // limits past the depth clamp to the depth
      lim = (limit_reg > CNT_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH) : limit_reg;
      if (cmd == CMD_ALLOC) begin
         if (stack_depth != '0) begin
            stack_depth = stack_depth - CNT_W'(1);
            r.granted = stack_mem[stack_depth[IDX_W-1:0]];
            is_free[r.granted] = 1'b0;
         end else if (fresh_next >= lim) begin
            r.status = STATUS_FULL;
         end else begin
            r.granted = fresh_next[IDX_W-1:0];
            fresh_next = fresh_next + CNT_W'(1);
         end
      end else begin
         if ({1'b0, idx} >= lim) begin
            r.status = STATUS_RANGE;
         end else if (is_free[idx] || stack_depth >= CNT_W'(SLOT_DEPTH)) begin
            r.status = STATUS_DUP;
         end else begin
            stack_mem[stack_depth[IDX_W-1:0]] = idx;
            stack_depth = stack_depth + CNT_W'(1);
            is_free[idx] = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_DEPTH; i++) is_free[i] = 1'b0;
         stack_depth = '0;
         fresh_next  = '0;
         limit_reg   = CNT_W'(1024);
         pending_grants.delete();
      end else begin
         if (csr_wr_en) limit_reg = csr_wr_data;
         if (req_valid && req_ready)
            pending_grants.insert(pending_grants.size(),
                                  predict_grant(req_command, req_slot_index));
         if (rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
               $display("%0t: unexpected word: granted %0d status %0d",
                        $time, rsp_granted_index, rsp_status);
               errors++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_granted_index !== want.granted) begin
                  $display("%0t: granted_index expected %0d actual %0d",
                           $time, want.granted, rsp_granted_index);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
            end
         end
      end
      mismatches  <= errors;
      outstanding <= pending_grants.size();
   end

endmodule

// ===== bench/index_allocator_free_stack_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for index_allocator_free_stack_core: drives requests, limit writes
// and response back-pressure. Depends on iafs_pkg and index_allocator_free_stack_checker.

module index_allocator_free_stack_core_tb
   import iafs_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;   // receiver stall long enough to back up the block
   localparam int HOLD_AT     = 300;   // response count at which that stall starts

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic             req_command    = CMD_ALLOC;
   logic [IDX_W-1:0] req_slot_index = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic [IDX_W-1:0] rsp_granted_index;
   logic [1:0]       rsp_status;
   logic             csr_wr_en      = 1'b0;
   logic [CNT_W-1:0] csr_wr_data    = '0;

   int               mismatches;
   int               outstanding;
   int               cycle_count    = 0;
   int               sent_words     = 0;
   logic [CNT_W-1:0] limit_now      = CNT_W'(1024);  // mirrors the limit register

   index_allocator_free_stack_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   index_allocator_free_stack_checker grant_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog; also covers the flag clear after reset
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("index_allocator_free_stack_core_tb: done, errors");
         $finish;
      end
   end

   // One request word. A random gap (none during calm stretches) goes first;
   // with no gap valid stays high straight into the next word.
   task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx);
      int unsigned gap;
      gap = ((sent_words % 100) >= 80) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_slot_index <= idx;
      do @(posedge clock); while (!req_ready);
      sent_words++;
   endtask

   // Stop offering and wait for every response. The first edge lets the
   // checker count a word accepted at the edge just gone.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Limit writes happen only with the block idle.
   task automatic set_slot_limit(input logic [CNT_W-1:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_now   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random word. Frees lean on a small pool of low indices so duplicates are
   // common, then on indices below the limit, then on any 10-bit value.
   task automatic random_word(input int unsigned alloc_pct);
      int unsigned      pick;
      int unsigned      eff;
      logic [IDX_W-1:0] idx;
      eff = (limit_now > CNT_W'(SLOT_DEPTH)) ? SLOT_DEPTH : limit_now;
      idx = IDX_W'($urandom);
      if ($urandom_range(0, 99) < alloc_pct) begin
         send_word(CMD_ALLOC, idx);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            idx = IDX_W'($urandom_range(0, 15));
         else if (pick < 75 && eff != 0)
            idx = IDX_W'($urandom_range(0, eff - 1));
         send_word(CMD_FREE, idx);
      end
   endtask

   initial begin : stimulus
      logic [CNT_W-1:0] lim;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset limit of 1024 ---
      send_word(CMD_ALLOC, '1);        // fresh 0
      send_word(CMD_ALLOC, '0);        // fresh 1
      send_word(CMD_FREE, 10'd0);      // push 0
      send_word(CMD_FREE, 10'd0);      // already free
      send_word(CMD_ALLOC, '1);        // pops 0
      send_word(CMD_FREE, 10'd1023);   // never issued, top index, accepted
      send_word(CMD_ALLOC, '0);        // pops 1023
      send_word(CMD_FREE, 10'd5);      // never issued; fresh counter hands it out later too
      send_word(CMD_FREE, 10'd512);
      send_word(CMD_ALLOC, '0);        // pops 512 (LIFO)
      send_word(CMD_ALLOC, '0);        // pops 5
      send_word(CMD_ALLOC, '1);        // fresh 2
      // limit of zero: nothing is valid
      set_slot_limit(CNT_W'(0));
      send_word(CMD_ALLOC, '0);        // full
      send_word(CMD_FREE, 10'd0);      // out of range
      send_word(CMD_FREE, 10'd1023);   // out of range
      // limit past the depth acts as the depth
      set_slot_limit(CNT_W'(2047));
      send_word(CMD_FREE, 10'd1023);
      send_word(CMD_FREE, 10'd1023);   // already free
      send_word(CMD_ALLOC, '1);        // pops 1023
      send_word(CMD_FREE, 10'd700);
      // limit lowered with 700 still stacked
      set_slot_limit(CNT_W'(1));
      send_word(CMD_ALLOC, '0);        // still hands out 700
      send_word(CMD_ALLOC, '0);        // fresh counter past limit: full
      send_word(CMD_FREE, 10'd0);
      send_word(CMD_FREE, 10'd1);      // out of range at limit 1
      send_word(CMD_ALLOC, '1);        // pops 0

      // --- random: alloc-heavy run at full depth to push the fresh counter up;
      //     the receiver's long stall lands in here ---
      set_slot_limit(CNT_W'(2047));
      repeat (700) random_word(97);

      // mixed phases over a spread of limits
      repeat (8) begin
         case ($urandom_range(0, 5))
            0:       lim = CNT_W'(0);
            1:       lim = CNT_W'(1);
            2:       lim = CNT_W'($urandom_range(2, 16));
            3:       lim = CNT_W'($urandom_range(17, 1023));
            4:       lim = CNT_W'(1024);
            default: lim = CNT_W'($urandom_range(1025, 2047));
         endcase
         set_slot_limit(lim);
         repeat (105) random_word(50);
      end

      // finish near exhaustion of the fresh counter at the maximum limit
      set_slot_limit(CNT_W'(1024));
      repeat (400) random_word(95);

      drain_responses();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("index_allocator_free_stack_core_tb: done, clean");
      else
         $display("index_allocator_free_stack_core_tb: done, errors");
      $finish;
   end

   // Response side: random gap per word, calm stretches, and one long stall
   // while the sender keeps going so the block backs up its input.
   initial begin : rsp_drain
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      forever begin
         if (taken == HOLD_AT)
            gap = LONG_HOLD;
         else if ((taken % 90) >= 70)
            gap = 0;
         else
            gap = $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
      end
   end

endmodule
